// File: hdl/length_prefixed_code_decoder_assert.svh
// assertion macros for the length prefixed code decoder checker
// no dependencies; included by the checker file
`ifndef LENGTH_PREFIXED_CODE_DECODER_ASSERT_SVH
`define LENGTH_PREFIXED_CODE_DECODER_ASSERT_SVH

// consequent must hold in the same cycle
`define LPCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpcd check failed");

// consequent must hold in the next cycle
`define LPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpcd check failed");

`endif

// File: hdl/lpcd_pkg.sv
// shared types, codes and table index helpers for the code decoder
// no dependencies
`timescale 1ns / 1ps

package lpcd_pkg;

	localparam int HEADER_BITS = 3;
	localparam int IDX_W       = 8;
	localparam int CMD_DEPTH   = 4;
	localparam int OUT_DEPTH   = 4;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] entry_len;
		logic [6:0] entry_code;
		logic [7:0] entry_char;
		logic       data_bit;
	} item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       message_end;
	} result_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_CLEAR,
		OP_LOOKUP,
		OP_NULL_SYM,
		OP_END
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [7:0]       chr;
	} cmd_t;

	// all-ones code of a given length
	function automatic logic [6:0] code_mask(input logic [2:0] len);
		logic [7:0] m;
		m = (8'd1 << len) - 8'd1;
		return m[6:0];
	endfunction

	// lengths packed back to back: base of length l is 2^l - l - 1
	function automatic logic [IDX_W-1:0] table_index(input logic [2:0] len,
		input logic [6:0] code);
		logic [7:0] base;
		base = (8'd1 << len) - 8'(len) - 8'd1;
		return base + 8'(code);
	endfunction

endpackage

// File: hdl/lpcd_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lpcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// File: hdl/lpcd_fifo.sv
// small register fifo with occupancy count
// no dependencies
`timescale 1ns / 1ps

module lpcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       empty,
	output logic                       full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/lpcd_front.sv
// front end: takes input beats, tracks header and code bits, emits table commands
// depends on lpcd_pkg
`timescale 1ns / 1ps

module lpcd_front #(
	parameter int MAX_CODE_LEN = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  lpcd_pkg::item_t item,
	output logic           cmd_push,
	output lpcd_pkg::cmd_t cmd
);

	localparam logic [2:0] MAX_LEN = 3'(MAX_CODE_LEN);

	logic       in_seg_q,    in_seg_d;
	logic [2:0] bits_left_q, bits_left_d;
	logic [6:0] acc_q,       acc_d;
	logic [2:0] seg_len_q,   seg_len_d;
	logic [6:0] acc_n;
	logic [2:0] bl_dec;

	always_comb begin
		in_seg_d    = in_seg_q;
		bits_left_d = bits_left_q;
		acc_d       = acc_q;
		seg_len_d   = seg_len_q;
		cmd_push    = 1'b0;
		cmd.op      = lpcd_pkg::OP_LOAD;
		cmd.idx     = lpcd_pkg::table_index(item.entry_len, item.entry_code);
		cmd.chr     = item.entry_char;
		acc_n       = {acc_q[5:0], item.data_bit};
		bl_dec      = (bits_left_q != 3'd0) ? bits_left_q - 3'd1 : 3'd0;
		if (accept) begin
			case (item.kind)
				lpcd_pkg::KIND_LOAD: begin
					if (item.entry_len != 3'd0 && item.entry_len <= MAX_LEN &&
						item.entry_code < lpcd_pkg::code_mask(item.entry_len)) begin
						cmd_push = 1'b1;
					end
				end
				lpcd_pkg::KIND_CLEAR: begin
					in_seg_d    = 1'b0;
					bits_left_d = 3'(lpcd_pkg::HEADER_BITS);
					acc_d       = '0;
					seg_len_d   = '0;
					cmd_push    = 1'b1;
					cmd.op      = lpcd_pkg::OP_CLEAR;
				end
				lpcd_pkg::KIND_DATA: begin
					acc_d       = acc_n;
					bits_left_d = bl_dec;
					if (bl_dec == 3'd0) begin
						if (!in_seg_q) begin
							if (acc_n[2:0] == 3'd0) begin
								// zero header: message end
								bits_left_d = 3'(lpcd_pkg::HEADER_BITS);
								acc_d       = '0;
								seg_len_d   = '0;
								cmd_push    = 1'b1;
								cmd.op      = lpcd_pkg::OP_END;
							end else begin
								in_seg_d    = 1'b1;
								seg_len_d   = acc_n[2:0];
								bits_left_d = acc_n[2:0];
								acc_d       = '0;
							end
						end else if (seg_len_q == 3'd0 ||
							acc_n == lpcd_pkg::code_mask(seg_len_q)) begin
							// all-ones code closes the segment
							in_seg_d    = 1'b0;
							bits_left_d = 3'(lpcd_pkg::HEADER_BITS);
							acc_d       = '0;
							seg_len_d   = '0;
						end else begin
							bits_left_d = seg_len_q;
							acc_d       = '0;
							cmd_push    = 1'b1;
							cmd.idx     = lpcd_pkg::table_index(seg_len_q, acc_n);
							cmd.op      = (seg_len_q > MAX_LEN) ? lpcd_pkg::OP_NULL_SYM
								: lpcd_pkg::OP_LOOKUP;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seg_q    <= 1'b0;
			bits_left_q <= 3'(lpcd_pkg::HEADER_BITS);
			acc_q       <= '0;
			seg_len_q   <= '0;
		end else begin
			in_seg_q    <= in_seg_d;
			bits_left_q <= bits_left_d;
			acc_q       <= acc_d;
			seg_len_q   <= seg_len_d;
		end
	end

endmodule

// File: hdl/lpcd_back.sv
// back end: runs table commands against the character ram and queues results
// depends on lpcd_pkg, lpcd_ram, lpcd_fifo
`timescale 1ns / 1ps

module lpcd_back #(
	parameter int MAX_CODE_LEN = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  lpcd_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	input  logic             pop,
	output logic             empty,
	output lpcd_pkg::result_t result
);

	localparam int AW    = MAX_CODE_LEN + 1;
	localparam int DEPTH = 2 ** AW;
	localparam int CW    = $clog2(lpcd_pkg::OUT_DEPTH + 1);

	logic [DEPTH-1:0]  valid_q;
	logic [AW-1:0]     addr;
	logic [7:0]        rdata;
	logic              produces;
	logic              room;
	logic              issue;
	logic              ram_en;
	logic              res_s1;
	logic              lookup_s1;
	logic              hit_s1;
	logic              end_s1;
	logic [CW-1:0]     out_count;
	logic              out_full;
	lpcd_pkg::result_t res_d;
	logic [$bits(lpcd_pkg::result_t)-1:0] out_data;

	assign addr     = cmd.idx[AW-1:0];
	assign produces = (cmd.op == lpcd_pkg::OP_LOOKUP) || (cmd.op == lpcd_pkg::OP_NULL_SYM) ||
		(cmd.op == lpcd_pkg::OP_END);
	assign room     = (out_count + CW'(res_s1)) < CW'(lpcd_pkg::OUT_DEPTH);
	assign issue    = !cmd_empty && (!produces || room);
	assign cmd_pop  = issue;
	assign ram_en   = issue && ((cmd.op == lpcd_pkg::OP_LOAD) ||
		(cmd.op == lpcd_pkg::OP_LOOKUP));

	lpcd_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (cmd.op == lpcd_pkg::OP_LOAD),
		.addr (addr),
		.wdata(cmd.chr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			res_s1  <= 1'b0;
		end else begin
			res_s1 <= issue && produces;
			if (issue && cmd.op == lpcd_pkg::OP_CLEAR) begin
				valid_q <= '0;
			end else if (issue && cmd.op == lpcd_pkg::OP_LOAD) begin
				valid_q[addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			lookup_s1 <= (cmd.op == lpcd_pkg::OP_LOOKUP);
			end_s1    <= (cmd.op == lpcd_pkg::OP_END);
			hit_s1    <= valid_q[addr];
		end
	end

	always_comb begin
		res_d.symbol      = (lookup_s1 && hit_s1) ? rdata : 8'd0;
		res_d.message_end = end_s1;
	end

	lpcd_fifo #(
		.WIDTH($bits(lpcd_pkg::result_t)),
		.DEPTH(lpcd_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_s1),
		.wr_data(res_d),
		.rd_en  (pop),
		.rd_data(out_data),
		.count  (out_count),
		.empty  (empty),
		.full   (out_full)
	);

	assign result = lpcd_pkg::result_t'(out_data);

	// room check keeps the output fifo from overflowing
	logic unused_full;
	assign unused_full = out_full;

endmodule

// File: hdl/length_prefixed_code_decoder.sv
// top level of the length prefixed code decoder
// depends on lpcd_pkg, lpcd_front, lpcd_fifo, lpcd_back
`timescale 1ns / 1ps

// Decodes a one-bit-per-beat message against a character table of codes of length
// 1 to MAX_CODE_LEN. Input beats load table entries, clear the table, or carry one
// message bit. A 3-bit header opens a segment of fixed-length codes, each giving one
// symbol; an all-ones code closes the segment and a zero header gives a message end
// result. One input beat is taken every cycle unless the command queue is full. A
// front end tracks the bit position and turns beats into table commands, a 4-entry
// command queue decouples it from the back end, which does one command a cycle
// unless a result-giving one waits for output queue room, on a single-port
// character ram with a registered read; results then pass a 4-entry output queue.
// No clearing pass after reset: per-entry valid bits mark loaded codes.

module length_prefixed_code_decoder #(
	parameter int MAX_CODE_LEN = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lpcd_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output lpcd_pkg::result_t result
);

	localparam int CMD_W  = $bits(lpcd_pkg::cmd_t);
	localparam int CMD_CW = $clog2(lpcd_pkg::CMD_DEPTH + 1);

	logic              accept;
	logic              cmd_push;
	lpcd_pkg::cmd_t    cmd_in;
	logic [CMD_W-1:0]  cmd_out;
	logic              cmd_empty;
	logic              cmd_pop;
	logic [CMD_CW-1:0] cmd_count;

	assign accept = push && !full;

	lpcd_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.cmd_push(cmd_push),
		.cmd     (cmd_in)
	);

	lpcd_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(lpcd_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.count  (cmd_count),
		.empty  (cmd_empty),
		.full   (full)
	);

	lpcd_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (lpcd_pkg::cmd_t'(cmd_out)),
		.cmd_pop  (cmd_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	logic unused_count;
	assign unused_count = ^cmd_count;

endmodule

// File: hdl/lpcd_checker.sv
// port level checks for the length prefixed code decoder, bound to the top level
// depends on lpcd_pkg and length_prefixed_code_decoder_assert.svh
`timescale 1ns / 1ps

`include "length_prefixed_code_decoder_assert.svh"

module lpcd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input lpcd_pkg::result_t result
);

	// end marker carries no character
	`LPCD_ASSERT_SAME(a_end_zero, clk, arst_n, !empty && result.message_end, result.symbol == 8'd0)
	// queue only fills on an accepted beat
	`LPCD_ASSERT_SAME(a_full_rise, clk, arst_n, $rose(full), $past(push && !full))
	// waiting result stays until taken
	`LPCD_ASSERT_NEXT(a_hold_valid, clk, arst_n, !empty && !pop, !empty)
	`LPCD_ASSERT_NEXT(a_hold_data, clk, arst_n, !empty && !pop, $stable(result))

endmodule

bind length_prefixed_code_decoder lpcd_checker u_lpcd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

// File: test/tb_top.sv
// testbench for length_prefixed_code_decoder: random load, clear and message bit beats
// with a scoreboard class that predicts decoded symbols; depends on lpcd_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
	import lpcd_pkg::*;

	localparam int MAX_LEN      = 7;
	localparam int N_ITEMS      = 1800;
	localparam int QUIET_TAIL   = 150;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	item_t plan [$];
	int    accepted;
	bit    quiet;

	function automatic logic [6:0] all_ones(input logic [2:0] len);
		return ~(7'h7f << len);
	endfunction

	function automatic logic [7:0] slot(input logic [2:0] len, input logic [6:0] code);
		return 8'((9'd1 << len) - 9'(len) - 9'd1 + 9'(code));
	endfunction

	class lpcd_board;
		logic [7:0] chars [256];
		bit         valid [256];
		bit         written [256];
		bit         in_seg;
		logic [2:0] left;
		logic [2:0] seg_len;
		logic [6:0] acc;
		result_t    symbols_due [$];
		int         errors;

		function void to_header();
			in_seg  = 1'b0;
			left    = 3'(HEADER_BITS);
			acc     = '0;
			seg_len = '0;
		endfunction

		function new();
			foreach (valid[i]) begin
				valid[i]   = 1'b0;
				written[i] = 1'b0;
				chars[i]   = '0;
			end
			errors = 0;
			to_header();
		endfunction

		function void take_item(input item_t it);
			logic [7:0] idx;
			result_t    r;
			case (it.kind)
			KIND_CLEAR: begin
				foreach (valid[i]) valid[i] = 1'b0;
				to_header();
			end
			KIND_LOAD: begin
				if (it.entry_len != 0 && it.entry_len <= MAX_LEN &&
					it.entry_code < all_ones(it.entry_len)) begin
					idx          = slot(it.entry_len, it.entry_code);
					chars[idx]   = it.entry_char;
					valid[idx]   = 1'b1;
					written[idx] = 1'b1;
				end
			end
			KIND_DATA: begin
				acc = {acc[5:0], it.data_bit};
				if (left != 0)
					left--;
				if (left == 0) begin
					if (!in_seg) begin
						if (acc[2:0] == 3'd0) begin
							to_header();
							r.symbol      = 8'd0;
							r.message_end = 1'b1;
							symbols_due.push_back(r);
						end else begin
							in_seg  = 1'b1;
							seg_len = acc[2:0];
							left    = acc[2:0];
							acc     = '0;
						end
					end else if (seg_len == 0 || acc == all_ones(seg_len)) begin
						to_header();
					end else begin
						idx           = slot(seg_len, acc);
						r.symbol      = valid[idx] ? chars[idx] : 8'd0;
						r.message_end = 1'b0;
						symbols_due.push_back(r);
						left = seg_len;
						acc  = '0;
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void check_symbol(input result_t got);
			result_t want;
			if (symbols_due.size() == 0) begin
				$error("unexpected result: symbol %0h message_end %0b",
					got.symbol, got.message_end);
				errors++;
				return;
			end
			want = symbols_due.pop_front();
			if (got.symbol !== want.symbol) begin
				$error("symbol: expected %0h, got %0h", want.symbol, got.symbol);
				errors++;
			end
			if (got.message_end !== want.message_end) begin
				$error("message_end: expected %0b, got %0b", want.message_end, got.message_end);
				errors++;
			end
		endfunction
	endclass

	lpcd_board board;

	length_prefixed_code_decoder #(.MAX_CODE_LEN(MAX_LEN)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	function automatic item_t any_item(input logic [1:0] kind);
		item_t it;
		it      = $bits(item_t)'($urandom);
		it.kind = kind;
		return it;
	endfunction

	function automatic item_t load_item(input logic [2:0] len, input logic [6:0] code,
		input logic [7:0] chr);
		item_t it;
		it            = any_item(KIND_LOAD);
		it.entry_len  = len;
		it.entry_code = code;
		it.entry_char = chr;
		return it;
	endfunction

	function automatic item_t bit_item(input logic b);
		item_t it;
		it          = any_item(KIND_DATA);
		it.data_bit = b;
		return it;
	endfunction

	function automatic void plan_bits(input logic [6:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			plan.push_back(bit_item(v[i]));
	endfunction

	function automatic void plan_message();
		int         nseg;
		int         ncode;
		logic [2:0] len;
		logic [6:0] code;
		nseg = $urandom_range(0, 3);
		repeat (nseg) begin
			len = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) :
				3'($urandom_range(1, 4));
			plan_bits(7'(len), 3);
			ncode = $urandom_range(0, 6);
			repeat (ncode) begin
				code = 7'($urandom_range(0, all_ones(len) - 1));
				if ($urandom_range(0, 2) == 0)
					plan.push_back(load_item(len, code, 8'($urandom)));
				plan_bits(code, len);
			end
			plan_bits(all_ones(len), len);
		end
		plan_bits(7'd0, 3);
	endfunction

	function automatic void plan_noise();
		logic [2:0] len;
		logic [6:0] code;
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 9))
			0: plan.push_back(any_item(KIND_SPARE));
			1: begin
				len  = 3'($urandom_range(0, 7));
				code = (len == 0) ? 7'($urandom) : 7'($urandom_range(all_ones(len), 127));
				plan.push_back(load_item(len, code, 8'($urandom)));
			end
			2, 3: begin
				len  = 3'($urandom_range(1, MAX_LEN));
				code = 7'($urandom_range(0, all_ones(len) - 1));
				plan.push_back(load_item(len, code, 8'($urandom)));
			end
			default: plan.push_back(bit_item(1'($urandom)));
			endcase
		end
	endfunction

	task automatic send(input item_t it);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		board.take_item(it);
		accepted++;
		quiet = (accepted >= N_ITEMS - QUIET_TAIL);
		@(negedge clk);
	endtask

	// never decode a code whose table slot was not written since reset
	task automatic feed(input item_t it);
		logic [6:0] code;
		logic [7:0] idx;
		if (it.kind == KIND_DATA && board.in_seg && board.left == 1) begin
			code = {board.acc[5:0], it.data_bit};
			idx  = slot(board.seg_len, code);
			if (code != all_ones(board.seg_len) && !board.written[idx])
				send(load_item(board.seg_len, code, 8'($urandom)));
		end
		send(it);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int stall;
		pop   = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				stall = $urandom_range(1, 6) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_symbol(result);
	end

	initial begin
		int stalled;
		stalled = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stalled = 0;
			else
				stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		board    = new();
		arst_n   = 1'b0;
		push     = 1'b0;
		item     = '0;
		accepted = 0;
		quiet    = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// table extremes, ignored beats, then short messages
		plan.push_back(load_item(3'd1, 7'd0, 8'hff));
		plan.push_back(load_item(3'd7, 7'd126, 8'h00));
		plan.push_back(load_item(3'd0, 7'h7f, 8'h11));
		plan.push_back(load_item(3'd7, 7'd127, 8'h33));
		plan.push_back(any_item(KIND_SPARE));
		plan_bits(7'd1, 3);
		plan_bits(7'd0, 1);
		plan_bits(7'd1, 1);
		plan_bits(7'd7, 3);
		plan_bits(7'd126, 7);
		plan_bits(7'd127, 7);
		plan_bits(7'd0, 3);
		plan_bits(7'd1, 3);
		plan.push_back(any_item(KIND_CLEAR));
		plan_bits(7'd1, 3);
		plan_bits(7'd0, 1);

		while (accepted < N_ITEMS) begin
			if (plan.size() == 0) begin
				case ($urandom_range(0, 19))
				0: plan.push_back(any_item(KIND_CLEAR));
				1, 2, 3, 4: plan_noise();
				default: plan_message();
				endcase
			end
			feed(plan.pop_front());
		end
		push <= 1'b0;

		while (board.symbols_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
